/* rtl/core/erasm_pkg.sv */
// Shared types and codes for the EoE fragment reassembler.
`timescale 1ns / 1ps
package erasm_pkg;

	// Input item kinds.
	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_DATA   = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;

	// Result event codes.
	localparam logic [2:0] EV_HEADER_OK = 3'd0;
	localparam logic [2:0] EV_STORED    = 3'd1;
	localparam logic [2:0] EV_SEQ_DROP  = 3'd2;
	localparam logic [2:0] EV_SIZE_DROP = 3'd3;
	localparam logic [2:0] EV_DISCARD   = 3'd4;
	localparam logic [2:0] EV_CLEARED   = 3'd5;

	// Saturation value of the expected fragment number, one past the highest fragment index (63).
	localparam logic [6:0] FRAG_SAT = 7'd64;

	typedef struct packed {
		logic        assembling;
		logic [3:0]  cur_id;
		logic [6:0]  exp_frag;
		logic [10:0] byte_count;
		logic [10:0] pending;
		logic        taken;
		logic        completes;
	} state_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  frame_id;
		logic [5:0]  frag_idx;
		logic        last;
		logic [10:0] frag_len;
		logic [7:0]  data;
	} item_t;

	typedef struct packed {
		logic [2:0]  ev;
		logic [7:0]  value;
		logic [10:0] offset;
		logic        done;
		logic [10:0] flen;
	} result_t;

endpackage

/* rtl/core/erasm_step.sv */
// Next-state and result logic for one reassembler item.
`timescale 1ns / 1ps
module erasm_step #(
	parameter int MAX_FRAME_BYTES = 1514
) (
	input  erasm_pkg::item_t   item,
	input  erasm_pkg::state_t  cur,
	output erasm_pkg::state_t  nxt,
	output erasm_pkg::result_t res
);
	import erasm_pkg::*;

	localparam logic [11:0] MAX_SUM = 12'(MAX_FRAME_BYTES);

	always_comb begin
		logic        seq_ok;
		logic [10:0] base_count;
		logic [6:0]  base_exp;
		logic [11:0] sum;

		nxt = cur;
		res = '0;
		res.ev = EV_DISCARD;
		seq_ok = 1'b0;
		base_count = cur.byte_count;
		base_exp = cur.exp_frag;
		sum = '0;

		unique case (item.kind)
			KIND_HEADER: begin
				nxt.pending = item.frag_len;
				nxt.taken = 1'b0;
				nxt.completes = 1'b0;
				res.ev = EV_HEADER_OK;
				seq_ok = (item.frag_idx == 6'd0) ||
					(cur.assembling && (item.frame_id == cur.cur_id) &&
					({1'b0, item.frag_idx} == cur.exp_frag));
				// Fragment zero restarts the frame.
				if (item.frag_idx == 6'd0) begin
					base_count = '0;
					base_exp = '0;
					nxt.cur_id = item.frame_id;
					nxt.assembling = 1'b1;
					nxt.byte_count = '0;
				end
				nxt.exp_frag = base_exp;
				sum = {1'b0, base_count} + {1'b0, item.frag_len};
				if (!seq_ok) begin
					nxt.assembling = 1'b0;
					res.ev = EV_SEQ_DROP;
				end else if (sum > MAX_SUM) begin
					nxt.assembling = 1'b0;
					nxt.byte_count = '0;
					res.ev = EV_SIZE_DROP;
				end else begin
					nxt.taken = 1'b1;
					if (base_exp < FRAG_SAT) begin
						nxt.exp_frag = base_exp + 7'd1;
					end
					if (item.last) begin
						nxt.assembling = 1'b0;
						if (item.frag_len == 11'd0) begin
							res.done = 1'b1;
						end else begin
							nxt.completes = 1'b1;
						end
					end
				end
			end
			KIND_DATA: begin
				if (cur.pending != 11'd0) begin
					nxt.pending = cur.pending - 11'd1;
					if (cur.taken) begin
						res.ev = EV_STORED;
						res.value = item.data;
						res.offset = cur.byte_count;
						nxt.byte_count = cur.byte_count + 11'd1;
						if ((cur.pending == 11'd1) && cur.completes) begin
							res.done = 1'b1;
							nxt.completes = 1'b0;
							nxt.taken = 1'b0;
						end
					end
				end
			end
			KIND_CLEAR: begin
				nxt = '0;
				res.ev = EV_CLEARED;
			end
			default: begin
				res.ev = EV_DISCARD;
			end
		endcase
		res.flen = nxt.byte_count;
	end

endmodule

/* rtl/core/eoe_fragment_reassembler.sv */
// Top level of the cut-through EoE fragment reassembler.
`timescale 1ns / 1ps
//
// Channel | Handshake           | Payload
// --------+---------------------+----------------------------------------------------
// input   | in_valid / in_ready | kind, frame_id, fragment_index, is_last_fragment,
//         |                     | fragment_length, data_byte
// output  | out_valid/out_ready | event_res, byte_value, byte_offset, frame_done,
//         |                     | frame_length
//
// Every item yields exactly one result; the block sustains one item per cycle while the output
// is not stalled. An accepted item is registered in the input stage, then its result and the
// updated reassembly state are registered together in the output stage.
// Reset clears the valid flags and the whole reassembly state; payload registers are not reset.
// When the output is stalled the input stage still takes one more item, then holds it,
// and in_ready drops until the result is taken.
module eoe_fragment_reassembler #(
	parameter int MAX_FRAME_BYTES = 1514
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [3:0]  frame_id,
	input  logic [5:0]  fragment_index,
	input  logic        is_last_fragment,
	input  logic [10:0] fragment_length,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  event_res,
	output logic [7:0]  byte_value,
	output logic [10:0] byte_offset,
	output logic        frame_done,
	output logic [10:0] frame_length
);
	import erasm_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    adv_s1;
	state_t  state_q;
	state_t  state_nxt;
	result_t res_nxt;
	result_t res_q;
	logic    out_valid_q;

	// The input stage moves on whenever the output register is empty or being emptied.
	assign adv_s1 = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.kind <= kind;
			item_s1.frame_id <= frame_id;
			item_s1.frag_idx <= fragment_index;
			item_s1.last <= is_last_fragment;
			item_s1.frag_len <= fragment_length;
			item_s1.data <= data_byte;
		end
	end

	erasm_step #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_step (
		.item(item_s1),
		.cur (state_q),
		.nxt (state_nxt),
		.res (res_nxt)
	);

	// The reassembly state commits in the same cycle as the result, so the next item
	// in the input stage already sees it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				state_q <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign event_res = res_q.ev;
	assign byte_value = res_q.value;
	assign byte_offset = res_q.offset;
	assign frame_done = res_q.done;
	assign frame_length = res_q.flen;

`ifndef NO_ASSERTIONS
	// A stored byte always lands inside the maximum frame.
	a_offset_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (event_res == EV_STORED)) |-> (byte_offset < 11'(MAX_FRAME_BYTES)))
		else $error("stored byte offset beyond maximum frame size");

	// Completion is only flagged on an accepted header or a stored byte.
	a_done_event: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_done) |->
		((event_res == EV_HEADER_OK) || (event_res == EV_STORED)))
		else $error("frame completion on an unexpected event");

	// The expected fragment number never passes its saturation point.
	a_exp_sat: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.exp_frag <= FRAG_SAT)
		else $error("expected fragment number past saturation");

	// A clear leaves an empty frame and never completes one.
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (event_res == EV_CLEARED)) |->
		((frame_length == 11'd0) && !frame_done))
		else $error("clear result carries frame state");
`endif

endmodule
